FILE: sv/csvt_pkg.sv
package csvt_pkg;

  localparam int MAX_FIELDS_DEF    = 255;
  localparam int POSITION_BITS_DEF = 24;

  localparam int REPORT_W    = 24;
  localparam int FNUM_W      = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] BOM_B0   = 8'hEF;
  localparam logic [7:0] BOM_B1   = 8'hBB;
  localparam logic [7:0] BOM_B2   = 8'hBF;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_END  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_UNQ    = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QSEEN  = 3'd3,
    MODE_CR     = 3'd4,
    MODE_QCR    = 3'd5
  } parse_mode_e;

  typedef enum logic [1:0] {
    BOM_NONE = 2'd0,
    BOM_EF   = 2'd1,
    BOM_EFBB = 2'd2,
    BOM_DONE = 2'd3
  } bom_e;

  typedef enum logic [2:0] {
    EV_BYTE = 3'd0,
    EV_FEND = 3'd1,
    EV_REND = 3'd2,
    EV_OK   = 3'd3,
    EV_ERR  = 3'd4
  } event_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_EMPTY      = 3'd1,
    ERR_LONE_CR    = 3'd2,
    ERR_QUOTE_UNQ  = 3'd3,
    ERR_JUNK_QUOTE = 3'd4,
    ERR_UNTERM     = 3'd5,
    ERR_MISMATCH   = 3'd6,
    ERR_TOO_MANY   = 3'd7
  } error_code_e;

  typedef struct packed {
    event_kind_e         kind;
    logic [7:0]          data;
    error_code_e         err;
    logic [REPORT_W-1:0] line;
    logic [REPORT_W-1:0] col;
    logic [FNUM_W-1:0]   fnum;
    logic                hdr;
  } event_t;

  // BOM bytes released ahead of the parsed events are implied by pre_n
  typedef struct packed {
    logic [1:0]       pre_n;
    logic [1:0]       op_n;
    event_t [2:0]     ev;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t bundle;
  } q_wr_t;

  typedef struct packed {
    logic    valid;
    bundle_t head;
  } q_rd_t;

endpackage

FILE: sv/csvt_front.sv
module csvt_front import csvt_pkg::*; #(
  parameter int MAX_FIELDS    = MAX_FIELDS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  func_e      func_i,
  input  logic [7:0] byte_i,
  output q_wr_t      wr_o,
  output logic       halted_o
);

  localparam int PW      = POSITION_BITS;
  localparam int FIELD_W = $clog2(MAX_FIELDS + 1);
  localparam logic [PW-1:0]      POS_MAX = '1;
  localparam logic [FIELD_W-1:0] FMAX    = FIELD_W'(MAX_FIELDS);

  parse_mode_e        mode_q, mode_d;
  bom_e               bom_q, bom_d;
  logic               saw_q, saw_d;
  logic [PW-1:0]      line_q, line_d;
  logic [PW-1:0]      col_q, col_d;
  logic [PW-1:0]      rsl_q, rsl_d;
  logic [PW-1:0]      qline_q, qline_d;
  logic [PW-1:0]      qcol_q, qcol_d;
  logic               ropen_q, ropen_d;
  logic [FIELD_W-1:0] fields_q, fields_d;
  logic [FIELD_W-1:0] hcount_q, hcount_d;
  logic               hdone_q, hdone_d;
  logic               mpend_q, mpend_d;
  logic [PW-1:0]      mline_q, mline_d;
  logic [FIELD_W-1:0] mfields_q, mfields_d;
  logic               halted_q, halted_d;

  logic         flush, do_parse, do_finish, req_rec, rec_ok, fin_tail;
  logic [1:0]   pre_n, n;
  event_t [2:0] evs;

  function automatic event_t mk_ev(input event_kind_e k, input logic [7:0] d,
                                   input error_code_e e, input logic [REPORT_W-1:0] l,
                                   input logic [REPORT_W-1:0] c,
                                   input logic [FNUM_W-1:0] f, input logic h);
    event_t ev;
    ev.kind = k;
    ev.data = d;
    ev.err  = e;
    ev.line = l;
    ev.col  = c;
    ev.fnum = f;
    ev.hdr  = h;
    return ev;
  endfunction

  always_comb begin
    mode_d    = mode_q;
    bom_d     = bom_q;
    saw_d     = saw_q;
    line_d    = line_q;
    col_d     = col_q;
    rsl_d     = rsl_q;
    qline_d   = qline_q;
    qcol_d    = qcol_q;
    ropen_d   = ropen_q;
    fields_d  = fields_q;
    hcount_d  = hcount_q;
    hdone_d   = hdone_q;
    mpend_d   = mpend_q;
    mline_d   = mline_q;
    mfields_d = mfields_q;
    halted_d  = halted_q;
    flush     = 1'b0;
    do_parse  = 1'b0;
    do_finish = 1'b0;
    req_rec   = 1'b0;
    rec_ok    = 1'b0;
    fin_tail  = 1'b0;
    pre_n     = 2'd0;
    n         = 2'd0;
    evs       = '0;

    if (accept_i && !halted_q) begin
      if (func_i == FUNC_END) begin
        flush     = 1'b1;
        do_finish = 1'b1;
      end else if (!saw_q && bom_q != BOM_DONE) begin
        case (bom_q)
          BOM_NONE: begin
            if (byte_i == BOM_B0) bom_d = BOM_EF;
            else begin flush = 1'b1; do_parse = 1'b1; end
          end
          BOM_EF: begin
            if (byte_i == BOM_B1) bom_d = BOM_EFBB;
            else begin flush = 1'b1; do_parse = 1'b1; end
          end
          BOM_EFBB: begin
            if (byte_i == BOM_B2) bom_d = BOM_DONE;
            else begin flush = 1'b1; do_parse = 1'b1; end
          end
          default: do_parse = 1'b1;
        endcase
      end else begin
        do_parse = 1'b1;
      end

      // held BOM bytes parse from reset state: fixed outcome
      if (flush) begin
        bom_d = BOM_DONE;
        case (bom_q)
          BOM_EF:   pre_n = 2'd1;
          BOM_EFBB: pre_n = 2'd2;
          default:  pre_n = 2'd0;
        endcase
        if (pre_n != 2'd0) begin
          mode_d  = MODE_UNQ;
          ropen_d = 1'b1;
          saw_d   = 1'b1;
          col_d   = PW'(pre_n) + PW'(1);
        end
      end

      if (do_parse) begin
        saw_d = 1'b1;
        case (mode_d)
          MODE_QCR: begin
            if (byte_i == CH_LF) begin
              evs[n] = mk_ev(EV_BYTE, CH_LF, ERR_NONE, REPORT_W'(rsl_d), '0,
                             FNUM_W'(fields_d), !hdone_d);
              n = n + 2'd1;
              if (line_d != POS_MAX) line_d = line_d + PW'(1);
              col_d  = PW'(1);
              mode_d = MODE_QUOTED;
            end else begin
              evs[n] = mk_ev(EV_ERR, 8'd0, ERR_LONE_CR, REPORT_W'(line_d),
                             REPORT_W'(col_d), FNUM_W'(fields_d), !hdone_d);
              n = n + 2'd1;
              halted_d = 1'b1;
            end
          end
          MODE_CR: begin
            if (byte_i == CH_LF) begin
              if (line_d != POS_MAX) line_d = line_d + PW'(1);
              col_d  = PW'(1);
              rsl_d  = line_d;
              mode_d = MODE_START;
            end else begin
              evs[n] = mk_ev(EV_ERR, 8'd0, ERR_LONE_CR, REPORT_W'(line_d),
                             REPORT_W'(col_d), FNUM_W'(fields_d), !hdone_d);
              n = n + 2'd1;
              halted_d = 1'b1;
            end
          end
          MODE_QUOTED: begin
            if (byte_i == CH_QUOTE) begin
              mode_d = MODE_QSEEN;
              if (col_d != POS_MAX) col_d = col_d + PW'(1);
            end else if (byte_i == CH_CR) begin
              mode_d = MODE_QCR;
            end else if (byte_i == CH_LF) begin
              evs[n] = mk_ev(EV_BYTE, CH_LF, ERR_NONE, REPORT_W'(rsl_d), '0,
                             FNUM_W'(fields_d), !hdone_d);
              n = n + 2'd1;
              if (line_d != POS_MAX) line_d = line_d + PW'(1);
              col_d = PW'(1);
            end else begin
              evs[n] = mk_ev(EV_BYTE, byte_i, ERR_NONE, REPORT_W'(rsl_d), '0,
                             FNUM_W'(fields_d), !hdone_d);
              n = n + 2'd1;
              if (col_d != POS_MAX) col_d = col_d + PW'(1);
            end
          end
          default: begin
            if (mode_d == MODE_QSEEN && byte_i == CH_QUOTE) begin
              // doubled quote inside a quoted field
              evs[n] = mk_ev(EV_BYTE, CH_QUOTE, ERR_NONE, REPORT_W'(rsl_d), '0,
                             FNUM_W'(fields_d), !hdone_d);
              n = n + 2'd1;
              if (col_d != POS_MAX) col_d = col_d + PW'(1);
              mode_d = MODE_QUOTED;
            end else if (byte_i == CH_LF || byte_i == CH_CR) begin
              req_rec = 1'b1;
            end else if (byte_i == CH_COMMA) begin
              if (mode_d == MODE_START) ropen_d = 1'b1;
              if (fields_d >= FMAX) begin
                evs[n] = mk_ev(EV_ERR, 8'd0, ERR_TOO_MANY, REPORT_W'(line_d),
                               REPORT_W'(col_d), FNUM_W'(fields_d), !hdone_d);
                n = n + 2'd1;
                halted_d = 1'b1;
              end else begin
                evs[n] = mk_ev(EV_FEND, 8'd0, ERR_NONE, REPORT_W'(rsl_d), '0,
                               FNUM_W'(fields_d), !hdone_d);
                n = n + 2'd1;
                fields_d = fields_d + FIELD_W'(1);
                mode_d   = MODE_START;
                if (col_d != POS_MAX) col_d = col_d + PW'(1);
              end
            end else if (mode_d == MODE_START) begin
              ropen_d = 1'b1;
              if (byte_i == CH_QUOTE) begin
                qline_d = line_d;
                qcol_d  = col_d;
                mode_d  = MODE_QUOTED;
              end else begin
                evs[n] = mk_ev(EV_BYTE, byte_i, ERR_NONE, REPORT_W'(rsl_d), '0,
                               FNUM_W'(fields_d), !hdone_d);
                n = n + 2'd1;
                mode_d = MODE_UNQ;
              end
              if (col_d != POS_MAX) col_d = col_d + PW'(1);
            end else if (byte_i == CH_QUOTE) begin
              evs[n] = mk_ev(EV_ERR, 8'd0, ERR_QUOTE_UNQ, REPORT_W'(line_d),
                             REPORT_W'(col_d), FNUM_W'(fields_d), !hdone_d);
              n = n + 2'd1;
              halted_d = 1'b1;
            end else if (mode_d == MODE_UNQ) begin
              evs[n] = mk_ev(EV_BYTE, byte_i, ERR_NONE, REPORT_W'(rsl_d), '0,
                             FNUM_W'(fields_d), !hdone_d);
              n = n + 2'd1;
              if (col_d != POS_MAX) col_d = col_d + PW'(1);
            end else begin
              evs[n] = mk_ev(EV_ERR, 8'd0, ERR_JUNK_QUOTE, REPORT_W'(line_d),
                             REPORT_W'(col_d), FNUM_W'(fields_d), !hdone_d);
              n = n + 2'd1;
              halted_d = 1'b1;
            end
          end
        endcase
      end

      if (do_finish) begin
        if (!saw_d) begin
          evs[n] = mk_ev(EV_ERR, 8'd0, ERR_EMPTY, REPORT_W'(1), REPORT_W'(1), '0,
                         !hdone_d);
          n = n + 2'd1;
          halted_d = 1'b1;
        end else if (mode_d == MODE_CR || mode_d == MODE_QCR) begin
          evs[n] = mk_ev(EV_ERR, 8'd0, ERR_LONE_CR, REPORT_W'(line_d),
                         REPORT_W'(col_d), FNUM_W'(fields_d), !hdone_d);
          n = n + 2'd1;
          halted_d = 1'b1;
        end else if (mode_d == MODE_QUOTED) begin
          evs[n] = mk_ev(EV_ERR, 8'd0, ERR_UNTERM, REPORT_W'(qline_d),
                         REPORT_W'(qcol_d), FNUM_W'(fields_d), !hdone_d);
          n = n + 2'd1;
          halted_d = 1'b1;
        end else begin
          req_rec  = ropen_d;
          fin_tail = 1'b1;
        end
      end

      // record close, shared by newline and end of document
      if (req_rec) begin
        if (fields_d >= FMAX) begin
          evs[n] = mk_ev(EV_ERR, 8'd0, ERR_TOO_MANY, REPORT_W'(line_d),
                         REPORT_W'(col_d), FNUM_W'(fields_d), !hdone_d);
          n = n + 2'd1;
          halted_d = 1'b1;
        end else begin
          evs[n] = mk_ev(EV_FEND, 8'd0, ERR_NONE, REPORT_W'(rsl_d), '0,
                         FNUM_W'(fields_d), !hdone_d);
          n = n + 2'd1;
          fields_d = fields_d + FIELD_W'(1);
          evs[n] = mk_ev(EV_REND, 8'd0, ERR_NONE, REPORT_W'(rsl_d), '0,
                         FNUM_W'(fields_d), !hdone_d);
          n = n + 2'd1;
          if (!hdone_d) begin
            hcount_d = fields_d;
            hdone_d  = 1'b1;
          end else if (fields_d != hcount_d && !mpend_d) begin
            mpend_d   = 1'b1;
            mline_d   = rsl_d;
            mfields_d = fields_d;
          end
          fields_d = '0;
          ropen_d  = 1'b0;
          mode_d   = MODE_START;
          rec_ok   = 1'b1;
        end
      end

      if (rec_ok && do_parse) begin
        if (byte_i == CH_CR) begin
          mode_d = MODE_CR;
        end else begin
          if (line_d != POS_MAX) line_d = line_d + PW'(1);
          col_d = PW'(1);
          rsl_d = line_d;
        end
      end

      if (fin_tail && !halted_d) begin
        if (mpend_d) begin
          evs[n] = mk_ev(EV_ERR, 8'd0, ERR_MISMATCH, REPORT_W'(mline_d), REPORT_W'(1),
                         FNUM_W'(mfields_d), !hdone_d);
        end else begin
          evs[n] = mk_ev(EV_OK, 8'd0, ERR_NONE, '0, '0, '0, !hdone_d);
        end
        n = n + 2'd1;
      end
    end

    // end mark always leaves the parser in its reset state
    if (accept_i && func_i == FUNC_END) begin
      mode_d    = MODE_START;
      bom_d     = BOM_NONE;
      saw_d     = 1'b0;
      line_d    = PW'(1);
      col_d     = PW'(1);
      rsl_d     = PW'(1);
      qline_d   = '0;
      qcol_d    = '0;
      ropen_d   = 1'b0;
      fields_d  = '0;
      hcount_d  = '0;
      hdone_d   = 1'b0;
      mpend_d   = 1'b0;
      mline_d   = '0;
      mfields_d = '0;
      halted_d  = 1'b0;
    end
  end

  assign wr_o.push         = accept_i && (pre_n != 2'd0 || n != 2'd0);
  assign wr_o.bundle.pre_n = pre_n;
  assign wr_o.bundle.op_n  = n;
  assign wr_o.bundle.ev    = evs;
  assign halted_o          = halted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_START;
      bom_q     <= BOM_NONE;
      saw_q     <= 1'b0;
      line_q    <= PW'(1);
      col_q     <= PW'(1);
      rsl_q     <= PW'(1);
      qline_q   <= '0;
      qcol_q    <= '0;
      ropen_q   <= 1'b0;
      fields_q  <= '0;
      hcount_q  <= '0;
      hdone_q   <= 1'b0;
      mpend_q   <= 1'b0;
      mline_q   <= '0;
      mfields_q <= '0;
      halted_q  <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      bom_q     <= bom_d;
      saw_q     <= saw_d;
      line_q    <= line_d;
      col_q     <= col_d;
      rsl_q     <= rsl_d;
      qline_q   <= qline_d;
      qcol_q    <= qcol_d;
      ropen_q   <= ropen_d;
      fields_q  <= fields_d;
      hcount_q  <= hcount_d;
      hdone_q   <= hdone_d;
      mpend_q   <= mpend_d;
      mline_q   <= mline_d;
      mfields_q <= mfields_d;
      halted_q  <= halted_d;
    end
  end

endmodule

FILE: sv/csvt_queue.sv
module csvt_queue import csvt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t wr_i,
  output logic  full_o,
  input  logic  pop_i,
  output q_rd_t rd_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  bundle_t           slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o   = (count_q == DEPTH_CNT);
  assign do_push  = wr_i.push && !full_o;
  assign do_pop   = pop_i && (count_q != '0);

  assign rd_o.valid = (count_q != '0);
  assign rd_o.head  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_W'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_W'(1);
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= wr_i.bundle;
  end

endmodule

FILE: sv/csvt_back.sv
module csvt_back import csvt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  q_rd_t  rd_i,
  output logic   pop_o,
  output logic   valid_o,
  input  logic   ready_i,
  output event_t ev_o,
  output logic   last_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  event_t     ev_q, ev_d;
  logic       last_q, last_d;
  logic       load, is_last, in_prefix;
  logic [2:0] total;
  logic [1:0] op_idx;

  assign total     = {1'b0, rd_i.head.pre_n} + {1'b0, rd_i.head.op_n};
  assign is_last   = (idx_q == total - 3'd1);
  assign in_prefix = (idx_q < {1'b0, rd_i.head.pre_n});
  assign op_idx    = 2'(idx_q - {1'b0, rd_i.head.pre_n});
  assign load      = rd_i.valid && (!valid_q || ready_i);
  assign pop_o     = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    ev_d    = ev_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      last_d  = is_last;
      if (in_prefix) begin
        // released BOM byte: header field 0 on line 1
        ev_d.kind = EV_BYTE;
        ev_d.data = (idx_q == 3'd0) ? BOM_B0 : BOM_B1;
        ev_d.err  = ERR_NONE;
        ev_d.line = REPORT_W'(1);
        ev_d.col  = '0;
        ev_d.fnum = '0;
        ev_d.hdr  = 1'b1;
      end else begin
        ev_d = rd_i.head.ev[op_idx];
      end
      idx_d = is_last ? 3'd0 : idx_q + 3'd1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  assign valid_o = valid_q;
  assign ev_o    = ev_q;
  assign last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    last_q <= last_d;
  end

endmodule

FILE: sv/csv_record_tokenizer.sv
// Strict CSV tokenizer. The input stream carries one document byte per word
// (tuser low) or an end-of-document mark (tuser high, tdata ignored). The
// output stream carries events: field bytes, field ends, record ends, and a
// final document-ok or error word; tlast marks the last word caused by one
// input word. Input words that cause nothing (BOM bytes, bytes after an
// error) leave no trace on the output.
// Throughput: one input word per cycle as long as each word causes at most
// one output word; the output register drains one word per cycle, so an
// input word that causes more than one word holds the output until the last
// of them is taken. A 4-deep event queue between parser and output stage
// absorbs the bursts. The first output word of an input word is written to
// a queue slot and then to the output register before it is presented.
// Receiver stall: output holds; the queue fills and s_axis_tready drops
// when it is full. Reset clears the parser to document start and empties
// the queue; no clearing pass is needed.
module csv_record_tokenizer import csvt_pkg::*; #(
  parameter int MAX_FIELDS    = MAX_FIELDS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic        s_axis_tuser,  // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // [7:0] data_byte, [10:8] error_code,
                                     // [34:11] report_line, [58:35] report_column,
                                     // [66:59] field_number, [71:67] zero
  output logic [3:0]  m_axis_tuser,  // [2:0] event_kind, [3] is_header
  output logic        m_axis_tlast
);

  q_wr_t  q_wr;
  q_rd_t  q_rd;
  logic   q_full, q_pop, s_accept, front_halted;
  event_t ev;
  func_e  func;

  assign s_axis_tready = !q_full;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign func          = func_e'(s_axis_tuser);

  csvt_front #(
    .MAX_FIELDS    (MAX_FIELDS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_accept),
    .func_i   (func),
    .byte_i   (s_axis_tdata),
    .wr_o     (q_wr),
    .halted_o (front_halted)
  );

  csvt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rd_o   (q_rd)
  );

  csvt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (q_rd),
    .pop_o   (q_pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .ev_o    (ev),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, ev.fnum, ev.col, ev.line, ev.err, ev.data};
  assign m_axis_tuser = {ev.hdr, ev.kind};

  // a word is never pushed while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr.push |-> !q_full)
    else $error("event bundle pushed into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_rd.valid)
    else $error("queue popped while empty");

  // ok and error words always close the run of their input word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (ev.kind == EV_OK || ev.kind == EV_ERR) |-> m_axis_tlast)
    else $error("terminal event without tlast");

  // once halted, a byte word produces no events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_halted && s_accept && func == FUNC_BYTE |-> !q_wr.push)
    else $error("event pushed after error");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import csvt_pkg::*;

  localparam logic [REPORT_W-1:0] POS_MAX = {POSITION_BITS_DEF{1'b1}};
  localparam int WORD_EVENTS_MAX = 6;

  typedef struct packed {
    event_kind_e         kind;
    logic [7:0]          data;
    error_code_e         err;
    logic [REPORT_W-1:0] line;
    logic [REPORT_W-1:0] col;
    logic [FNUM_W-1:0]   fnum;
    logic                hdr;
    logic                last;
  } csv_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  csv_record_tokenizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Tokenizer predictor state
  // ---------------------------------------------------------------------------
  parse_mode_e         mode;
  bom_e                bom_seen;
  bit                  any_content;
  logic [REPORT_W-1:0] line_cnt, col_cnt, rec_line, qopen_line, qopen_col;
  bit                  rec_open;
  logic [FNUM_W-1:0]   fld_cnt, hdr_fields;
  bit                  hdr_done;
  bit                  mm_pending;
  logic [REPORT_W-1:0] mm_line;
  logic [FNUM_W-1:0]   mm_fields;
  bit                  halted;

  csv_event_t word_events [WORD_EVENTS_MAX];
  int         word_event_n;
  csv_event_t expected_events [$];

  bit   steady;
  int   fail_count;
  int   words_sent;
  int   events_checked;
  int   docs_sent;
  logic [7:0] doc_bytes [$];

  function automatic void reset_tokenizer();
    mode        = MODE_START;
    bom_seen    = BOM_NONE;
    any_content = 1'b0;
    line_cnt    = 1;
    col_cnt     = 1;
    rec_line    = 1;
    qopen_line  = 0;
    qopen_col   = 0;
    rec_open    = 1'b0;
    fld_cnt     = 0;
    hdr_fields  = 0;
    hdr_done    = 1'b0;
    mm_pending  = 1'b0;
    mm_line     = 0;
    mm_fields   = 0;
    halted      = 1'b0;
  endfunction

  function automatic void add_event(event_kind_e kind, logic [7:0] data, error_code_e err,
                                    logic [REPORT_W-1:0] line, logic [REPORT_W-1:0] col,
                                    logic [FNUM_W-1:0] fnum);
    csv_event_t ev;
    if (word_event_n >= WORD_EVENTS_MAX) return;
    ev.kind = kind;
    ev.data = data;
    ev.err  = err;
    ev.line = line;
    ev.col  = col;
    ev.fnum = fnum;
    ev.hdr  = !hdr_done;
    ev.last = 1'b0;
    word_events[word_event_n] = ev;
    word_event_n++;
  endfunction

  function automatic void raise_error(error_code_e code, logic [REPORT_W-1:0] line,
                                      logic [REPORT_W-1:0] col, logic [FNUM_W-1:0] fnum);
    add_event(EV_ERR, 8'h00, code, line, col, fnum);
    halted = 1'b1;
  endfunction

  function automatic void col_step();
    if (col_cnt < POS_MAX) col_cnt++;
  endfunction

  function automatic void line_step();
    if (line_cnt < POS_MAX) line_cnt++;
    col_cnt = 1;
  endfunction

  function automatic void field_byte(logic [7:0] b);
    add_event(EV_BYTE, b, ERR_NONE, rec_line, '0, fld_cnt);
  endfunction

  function automatic bit close_field();
    if (fld_cnt >= MAX_FIELDS_DEF) begin
      raise_error(ERR_TOO_MANY, line_cnt, col_cnt, fld_cnt);
      return 1'b0;
    end
    add_event(EV_FEND, 8'h00, ERR_NONE, rec_line, '0, fld_cnt);
    fld_cnt++;
    return 1'b1;
  endfunction

  function automatic bit close_record();
    if (!close_field()) return 1'b0;
    add_event(EV_REND, 8'h00, ERR_NONE, rec_line, '0, fld_cnt);
    if (!hdr_done) begin
      hdr_fields = fld_cnt;
      hdr_done   = 1'b1;
    end else if (fld_cnt != hdr_fields && !mm_pending) begin
      mm_pending = 1'b1;
      mm_line    = rec_line;
      mm_fields  = fld_cnt;
    end
    fld_cnt  = 0;
    rec_open = 1'b0;
    mode     = MODE_START;
    return 1'b1;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    bit nl;
    nl = (b == CH_LF) || (b == CH_CR);
    any_content = 1'b1;
    case (mode)
      MODE_QCR: begin
        if (b == CH_LF) begin
          field_byte(CH_LF);
          line_step();
          mode = MODE_QUOTED;
        end else begin
          raise_error(ERR_LONE_CR, line_cnt, col_cnt, fld_cnt);
        end
        return;
      end
      MODE_CR: begin
        if (b == CH_LF) begin
          line_step();
          rec_line = line_cnt;
          mode     = MODE_START;
        end else begin
          raise_error(ERR_LONE_CR, line_cnt, col_cnt, fld_cnt);
        end
        return;
      end
      MODE_QUOTED: begin
        if (b == CH_QUOTE) begin
          mode = MODE_QSEEN;
          col_step();
        end else if (b == CH_CR) begin
          mode = MODE_QCR;
        end else if (b == CH_LF) begin
          field_byte(CH_LF);
          line_step();
        end else begin
          field_byte(b);
          col_step();
        end
        return;
      end
      default: ;
    endcase
    // doubled quote inside a quoted field
    if (mode == MODE_QSEEN && b == CH_QUOTE) begin
      field_byte(CH_QUOTE);
      col_step();
      mode = MODE_QUOTED;
      return;
    end
    if (nl) begin
      if (!close_record()) return;
      if (b == CH_CR) begin
        mode = MODE_CR;
      end else begin
        line_step();
        rec_line = line_cnt;
      end
      return;
    end
    if (mode == MODE_START) begin
      rec_open = 1'b1;
      if (b == CH_QUOTE) begin
        qopen_line = line_cnt;
        qopen_col  = col_cnt;
        mode       = MODE_QUOTED;
      end else if (b == CH_COMMA) begin
        if (!close_field()) return;
      end else begin
        field_byte(b);
        mode = MODE_UNQ;
      end
      col_step();
      return;
    end
    if (mode == MODE_UNQ && b == CH_QUOTE) begin
      raise_error(ERR_QUOTE_UNQ, line_cnt, col_cnt, fld_cnt);
      return;
    end
    if (b == CH_COMMA) begin
      if (!close_field()) return;
      mode = MODE_START;
      col_step();
      return;
    end
    if (mode == MODE_UNQ) begin
      field_byte(b);
      col_step();
      return;
    end
    raise_error(ERR_JUNK_QUOTE, line_cnt, col_cnt, fld_cnt);
  endfunction

  // held BOM prefix bytes turn out to be document content
  function automatic void release_bom();
    int held;
    held = (bom_seen == BOM_DONE) ? 0 : int'(bom_seen);
    bom_seen = BOM_DONE;
    if (held >= 1) parse_byte(BOM_B0);
    if (held >= 2) parse_byte(BOM_B1);
  endfunction

  function automatic void close_document();
    release_bom();
    if (!any_content) begin
      raise_error(ERR_EMPTY, 1, 1, 0);
      return;
    end
    if (mode == MODE_CR || mode == MODE_QCR) begin
      raise_error(ERR_LONE_CR, line_cnt, col_cnt, fld_cnt);
      return;
    end
    if (mode == MODE_QUOTED) begin
      raise_error(ERR_UNTERM, qopen_line, qopen_col, fld_cnt);
      return;
    end
    if (rec_open && !close_record()) return;
    if (mm_pending) raise_error(ERR_MISMATCH, mm_line, 1, mm_fields);
    else add_event(EV_OK, 8'h00, ERR_NONE, '0, '0, '0);
  endfunction

  function automatic void predict_word(func_e f, logic [7:0] b);
    word_event_n = 0;
    if (f == FUNC_END) begin
      if (!halted) close_document();
      reset_tokenizer();
    end else if (!halted) begin
      if (!any_content && bom_seen != BOM_DONE) begin
        if (bom_seen == BOM_NONE && b == BOM_B0) begin
          bom_seen = BOM_EF;
          return;
        end
        if (bom_seen == BOM_EF && b == BOM_B1) begin
          bom_seen = BOM_EFBB;
          return;
        end
        if (bom_seen == BOM_EFBB && b == BOM_B2) begin
          bom_seen = BOM_DONE;
          return;
        end
        release_bom();
      end
      if (!halted) parse_byte(b);
    end
    for (int i = 0; i < word_event_n; i++) begin
      word_events[i].last = (i == word_event_n - 1);
      expected_events.insert(expected_events.size(), word_events[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_word(func_e f, logic [7:0] b);
    @(negedge clk_i);
    if (!steady && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_word(f, b);
    words_sent++;
    if (f == FUNC_END) docs_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(FUNC_BYTE, s[i]);
  endtask

  task automatic send_doc(string s);
    send_text(s);
    send_word(FUNC_END, 8'h00);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    csv_event_t ev;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected output word: tuser %0h tdata %0h", m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        ev = expected_events.pop_front();
        compare_field("event_kind", ev.kind, m_axis_tuser[2:0]);
        compare_field("is_header", ev.hdr, m_axis_tuser[3]);
        compare_field("data_byte", ev.data, m_axis_tdata[7:0]);
        compare_field("error_code", ev.err, m_axis_tdata[10:8]);
        compare_field("report_line", ev.line, m_axis_tdata[34:11]);
        compare_field("report_column", ev.col, m_axis_tdata[58:35]);
        compare_field("field_number", ev.fnum, m_axis_tdata[66:59]);
        compare_field("last", ev.last, m_axis_tlast);
        events_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_records();
    send_text("id,name\n1,\"a,\"\"b\"\"\"\015\n");
    send_text("\"l1\015\nl2\nl3\",\n");
    send_doc("x,y");
    // extreme byte values as plain content
    send_word(FUNC_BYTE, 8'h00);
    send_word(FUNC_BYTE, 8'hFF);
    send_doc(",z\n");
  endtask

  task automatic test_bom_handling();
    send_word(FUNC_END, 8'h00);
    send_text("\357\273\277");
    send_word(FUNC_END, 8'h00);
    send_doc("\357\273\277a\n");
    send_doc("\357a");
    send_doc("\357\273");
    send_doc("\357\273q");
  endtask

  task automatic test_syntax_errors();
    send_doc("a\015x,zz");
    send_doc("a\015");
    send_doc("a\"b");
    send_doc("\"a\"b");
    send_doc("\"a,\n");
    send_doc("\"a\015b");
    send_doc("\"a\015");
  endtask

  task automatic test_count_mismatch();
    send_doc("a,b\nc\nd,e,f\n");
    // a later syntax error wins over a held mismatch
    send_doc("a\nb,c\n\"");
  endtask

  // long run with no idling on either side
  task automatic test_field_limit();
    steady = 1'b1;
    repeat (MAX_FIELDS_DEF) send_word(FUNC_BYTE, CH_COMMA);
    send_doc("\n");
    steady = 1'b0;
  endtask

  function automatic void append_byte(logic [7:0] b);
    doc_bytes.insert(doc_bytes.size(), b);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_COMMA || b == CH_QUOTE || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic void add_field();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 15) return;
    if (pick < 60) begin
      len = $urandom_range(1, 4);
      repeat (len) append_byte(plain_byte());
      return;
    end
    append_byte(CH_QUOTE);
    len = $urandom_range(0, 4);
    repeat (len) begin
      case ($urandom_range(0, 5))
        0: append_byte(CH_COMMA);
        1: begin
          append_byte(CH_QUOTE);
          append_byte(CH_QUOTE);
        end
        2: append_byte(CH_LF);
        3: begin
          append_byte(CH_CR);
          append_byte(CH_LF);
        end
        default: append_byte(plain_byte());
      endcase
    end
    append_byte(CH_QUOTE);
  endfunction

  task automatic random_document();
    int prefix;
    int hdr_n;
    int rec_n;
    int nf;
    int pos;
    doc_bytes.delete();
    prefix = $urandom_range(0, 99);
    if (prefix < 15) begin
      append_byte(BOM_B0);
      append_byte(BOM_B1);
      append_byte(BOM_B2);
    end else if (prefix < 20) begin
      append_byte(BOM_B0);
    end else if (prefix < 23) begin
      append_byte(BOM_B0);
      append_byte(BOM_B1);
    end
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 10)) append_byte(8'($urandom_range(0, 255)));
    end else begin
      hdr_n = $urandom_range(1, 4);
      rec_n = $urandom_range(1, 5);
      for (int r = 0; r < rec_n; r++) begin
        nf = ($urandom_range(0, 99) < 80) ? hdr_n : $urandom_range(1, 5);
        for (int f = 0; f < nf; f++) begin
          if (f > 0) append_byte(CH_COMMA);
          add_field();
        end
        if (r < rec_n - 1 || $urandom_range(0, 99) < 75) begin
          if ($urandom_range(0, 99) < 60) begin
            append_byte(CH_LF);
          end else begin
            append_byte(CH_CR);
            append_byte(CH_LF);
          end
        end
      end
      // break the document now and then
      if ($urandom_range(0, 99) < 20 && doc_bytes.size() > 0) begin
        pos = $urandom_range(0, doc_bytes.size() - 1);
        case ($urandom_range(0, 2))
          0: doc_bytes.insert(pos, CH_QUOTE);
          1: doc_bytes.insert(pos, CH_CR);
          default: doc_bytes.insert(pos, 8'($urandom_range(0, 255)));
        endcase
      end
    end
    foreach (doc_bytes[i]) send_word(FUNC_BYTE, doc_bytes[i]);
    send_word(FUNC_END, 8'h00);
  endtask

  task automatic test_random_documents();
    int first_word;
    first_word = words_sent;
    while (words_sent - first_word < 50) begin
      random_document();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    s_axis_tuser   = FUNC_BYTE;
    steady         = 1'b0;
    fail_count     = 0;
    words_sent     = 0;
    events_checked = 0;
    docs_sent      = 0;
    reset_tokenizer();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_records();
    test_bom_handling();
    test_syntax_errors();
    test_count_mismatch();
    test_field_limit();
    test_random_documents();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d documents in %0d input words; %0d output words checked.",
             docs_sent, words_sent, events_checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d output words outstanding", expected_events.size());
    $display("simulation failed");
    $finish;
  end

endmodule
